### rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// shared widths, state encoding and alu word types for the two-squares test
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int N_WIDTH   = 40;                   // input word width
  localparam int R_WIDTH   = (N_WIDTH + 1) / 2;    // integer root width
  localparam int W_WIDTH   = N_WIDTH + 1;          // alu / accumulator width
  localparam int P_WIDTH   = 2 * R_WIDTH;          // input padded to digit pairs
  localparam int CNT_WIDTH = $clog2(R_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_CMP,
    S_UPD,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [W_WIDTH-1:0] op_a;
    logic [W_WIDTH-1:0] op_b;
    logic               sub;
  } alu_req_t;

  typedef struct packed {
    logic [W_WIDTH-1:0] res;
    logic               zero;
    logic               borrow;
  } alu_rsp_t;

endpackage

### rtl/sst_alu.sv
// ----------------------------------------------------------------------------
// sst_alu
// shared add / subtract unit with zero and borrow flags
// ----------------------------------------------------------------------------
module sst_alu import sst_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [W_WIDTH:0]   sum;
  logic [W_WIDTH-1:0] op_b_eff;

  assign op_b_eff = req_i.sub ? ~req_i.op_b : req_i.op_b;
  assign sum      = {1'b0, req_i.op_a} + {1'b0, op_b_eff} + (W_WIDTH + 1)'(req_i.sub);

  assign rsp_o.res    = sum[W_WIDTH-1:0];
  assign rsp_o.zero   = (sum[W_WIDTH-1:0] == '0);
  assign rsp_o.borrow = req_i.sub & ~sum[W_WIDTH];

endmodule

### rtl/sum_of_two_squares_test_top.sv
// ----------------------------------------------------------------------------
// sum_of_two_squares_test_top
// decides whether an unsigned word is a sum of two squares
// ----------------------------------------------------------------------------
// usage:
//   a word is taken on number_i at a rising edge with start high and busy
//   low. busy stays high until the answer has been shown. the answer is on
//   is_sum_o, marked by done_o high for exactly one cycle; the receiver cannot
//   stall, so it must take the word in that cycle.
// operation:
//   phase 1 forms b = isqrt(n) and n - b*b, one digit pair per cycle.
//   phase 2 walks a up and b down, keeping a*a and n - b*b by adding odd
//   numbers; every step is a compare and then, unless it ends the scan, an
//   update, both through the one shared adder.
// timing:
//   phase 2 ends once a passes b or a*a equals n - b*b; a zero word answers
//   in the cycle after it is taken. one word is in flight at a time;
//   the next word can be taken in the cycle after the answer.
// reset:
//   rst_ni low returns the sequencer to idle at once and drops done_o.
// ----------------------------------------------------------------------------
module sum_of_two_squares_test_top import sst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [N_WIDTH-1:0] number_i,
  output logic               done_o,
  output logic               is_sum_o
);

  state_e state_q, state_d;

  // digit-pair shift register holding the input during the root phase
  logic [P_WIDTH-1:0]   np_q, np_d;
  logic [CNT_WIDTH-1:0] cnt_q, cnt_d;
  // root while it is built, then the descending pointer b
  logic [R_WIDTH-1:0]   b_q, b_d;
  // root remainder, then n - b*b
  logic [W_WIDTH-1:0]   rem_q, rem_d;
  // ascending pointer a and its square
  logic [R_WIDTH:0]     a_q, a_d;
  logic [W_WIDTH-1:0]   aa_q, aa_d;
  logic                 inc_q, inc_d;
  logic                 ans_q, ans_d;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic [R_WIDTH+1:0] root_cur;
  logic [R_WIDTH+1:0] root_trial;

  sst_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // next digit pair appended to the partial remainder
  assign root_cur   = {rem_q[R_WIDTH-1:0], np_q[P_WIDTH-1 -: 2]};
  assign root_trial = {b_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    np_q  <= np_d;
    cnt_q <= cnt_d;
    b_q   <= b_d;
    rem_q <= rem_d;
    a_q   <= a_d;
    aa_q  <= aa_d;
    inc_q <= inc_d;
    ans_q <= ans_d;
  end

  // operand select for the shared adder
  always_comb begin
    alu_req.op_a = rem_q;
    alu_req.op_b = aa_q;
    alu_req.sub  = 1'b1;
    case (state_q)
      S_ROOT: begin
        // trial subtract of 4b + 1 from the partial remainder
        alu_req.op_a = W_WIDTH'(root_cur);
        alu_req.op_b = W_WIDTH'(root_trial);
      end
      S_UPD: begin
        alu_req.sub = 1'b0;
        if (inc_q) begin
          // (a+1)^2 = a^2 + 2a + 1
          alu_req.op_a = aa_q;
          alu_req.op_b = W_WIDTH'({a_q, 1'b1});
        end else begin
          // n - (b-1)^2 = n - b^2 + 2b - 1
          alu_req.op_a = rem_q;
          alu_req.op_b = W_WIDTH'({b_q - R_WIDTH'(1), 1'b1});
        end
      end
      default: begin
        // rem - aa compare
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    np_d    = np_q;
    cnt_d   = cnt_q;
    b_d     = b_q;
    rem_d   = rem_q;
    a_d     = a_q;
    aa_d    = aa_q;
    inc_d   = inc_q;
    ans_d   = ans_q;

    busy     = (state_q != S_IDLE);
    done_o   = 1'b0;
    is_sum_o = ans_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          np_d  = P_WIDTH'(number_i);
          cnt_d = CNT_WIDTH'(R_WIDTH - 1);
          b_d   = '0;
          rem_d = '0;
          // zero never enters the scan, so it is answered here
          if (number_i == '0) begin
            ans_d   = 1'b0;
            state_d = S_DONE;
          end else begin
            state_d = S_ROOT;
          end
        end
      end

      S_ROOT: begin
        // one restoring square-root digit per cycle
        rem_d = alu_rsp.borrow ? W_WIDTH'(root_cur) : alu_rsp.res;
        b_d   = {b_q[R_WIDTH-2:0], ~alu_rsp.borrow};
        np_d  = np_q << 2;
        if (cnt_q == '0) begin
          a_d     = '0;
          aa_d    = '0;
          state_d = S_CMP;
        end else begin
          cnt_d = cnt_q - CNT_WIDTH'(1);
        end
      end

      S_CMP: begin
        // rem - aa: zero means a hit, borrow means aa is too large
        if (a_q > {1'b0, b_q}) begin
          ans_d   = 1'b0;
          state_d = S_DONE;
        end else if (alu_rsp.zero) begin
          ans_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          inc_d   = ~alu_rsp.borrow;
          state_d = S_UPD;
        end
      end

      S_UPD: begin
        if (inc_q) begin
          aa_d = alu_rsp.res;
          a_d  = a_q + (R_WIDTH + 1)'(1);
        end else begin
          rem_d = alu_rsp.res;
          b_d   = b_q - R_WIDTH'(1);
        end
        state_d = S_CMP;
      end

      S_DONE: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // an accepted word always makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // the done strobe never stays high on back-to-back cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done strobe held for more than one cycle");

  // pointer a never runs more than one past b during the scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (a_q <= ({1'b0, b_q} + (R_WIDTH + 1)'(1))))
    else $error("pointer a ran past b");

  // n - b*b never exceeds the input width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP || state_q == S_UPD) |-> !rem_q[W_WIDTH-1])
    else $error("remainder overflow");

  // a decrement of b is only taken from a nonzero b
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && !inc_q) |-> (b_q != '0))
    else $error("pointer b decremented below zero");

endmodule
